// ===== hw/rtl/hcb_pkg.sv =====
// ---------------------------------------------------------------------------
// hcb_pkg
// Shared command and status types for the tree builder controller and
// datapath.
// ---------------------------------------------------------------------------
package hcb_pkg;

  typedef struct packed {
    logic load;        // store the input beat as a leaf
    logic scan_start;  // reset min trackers, start node scan
    logic scan_step;   // examine node at scan pointer
    logic merge;       // write merged node from min trackers
    logic walk_start;  // start code walk for current leaf
    logic walk_step;   // climb one level
    logic emit;        // capture result in output register
    logic next_leaf;   // advance leaf pointer
    logic clear_count; // drop leaf count after emission
  } hcb_cmd_t;

  typedef struct packed {
    logic scan_done;   // scan pointer reached merge slot
    logic build_done;  // merge slot is the root slot
    logic walk_done;   // current node has no parent
    logic leaf_done;   // current leaf is the last
    logic single;      // fewer than two leaves stored
  } hcb_sts_t;

endpackage

// ===== hw/rtl/huffman_code_builder_core.sv =====
// ---------------------------------------------------------------------------
// huffman_code_builder_core
// Loads leaf weights one per beat, builds the code tree and emits one code
// beat per leaf. The build then runs N-1 merges for N leaves, each after a
// serial scan over the node store up to the merge slot. Each leaf's code is
// then found by climbing to the root one level per cycle. Inputs are stalled
// from the final leaf until the last code beat is issued.
// ---------------------------------------------------------------------------
module huffman_code_builder_core import hcb_pkg::*; #(
  parameter int MAX_LEAVES  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_weight,
  input  logic        in_last_leaf,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_leaf_index,
  output logic [3:0]  out_code_length,
  output logic [14:0] out_code_bits,
  output logic        out_last_code
);

  hcb_cmd_t cmd;
  hcb_sts_t sts;

  hcb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_last_leaf,
    .out_valid, .out_stall, .cmd, .sts
  );

  hcb_datapath #(.MAX_LEAVES(MAX_LEAVES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_weight,
    .res_leaf_index(out_leaf_index), .res_code_length(out_code_length),
    .res_code_bits(out_code_bits), .res_last_code(out_last_code)
  );

endmodule

// ===== hw/rtl/hcb_datapath.sv =====
// ---------------------------------------------------------------------------
// hcb_datapath
// Node store, sequential min-pair scan, merge write and leaf code walk.
// ---------------------------------------------------------------------------
module hcb_datapath import hcb_pkg::*; #(
  parameter int MAX_LEAVES  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  hcb_cmd_t    cmd,
  output hcb_sts_t    sts,
  input  logic [15:0] in_weight,
  output logic [3:0]  res_leaf_index,
  output logic [3:0]  res_code_length,
  output logic [14:0] res_code_bits,
  output logic        res_last_code
);

  localparam int SLOTS = 2 * MAX_LEAVES - 1;
  localparam int IW    = $clog2(SLOTS + 1);
  localparam int NW    = WEIGHT_BITS + $clog2(MAX_LEAVES);
  localparam int CW    = $clog2(MAX_LEAVES + 1);

  logic [NW-1:0]    weight_mem [SLOTS];
  logic [IW-1:0]    parent_mem [SLOTS];
  logic             is_left_mem [SLOTS];
  logic [SLOTS-1:0] has_parent_r;

  logic [CW-1:0] leaf_count_r;
  logic [IW-1:0] slot_r, ptr_r, leaf_r, node_r;
  logic [NW-1:0] min1_r, min2_r;
  logic [IW-1:0] lo_r, hi_r;
  logic          have1_r, have2_r;
  logic [4:0]    depth_r;
  logic [14:0]   code_r;

  logic [NW-1:0] scan_w;
  logic [IW-1:0] node_par;
  logic          node_left;
  logic [IW-1:0] leaf_count_x;

  assign scan_w       = weight_mem[ptr_r[$clog2(SLOTS)-1:0]];
  assign node_par     = parent_mem[node_r[$clog2(SLOTS)-1:0]];
  assign node_left    = is_left_mem[node_r[$clog2(SLOTS)-1:0]];
  assign leaf_count_x = IW'(leaf_count_r);

  // the root is the merge at slot 2N-2; compare one bit wider to avoid wrap
  assign sts.scan_done  = (ptr_r == slot_r);
  assign sts.build_done = (({1'b0, slot_r} + (IW+1)'(2)) >= {leaf_count_x, 1'b0});
  assign sts.walk_done  = !has_parent_r[node_r[$clog2(SLOTS)-1:0]];
  assign sts.leaf_done  = (leaf_r + IW'(1) == leaf_count_x);
  assign sts.single     = (leaf_count_r < CW'(2));

  // store leaves and merged nodes
  always_ff @(posedge clk) begin
    if (cmd.load && leaf_count_r < CW'(MAX_LEAVES))
      weight_mem[leaf_count_r[$clog2(SLOTS)-1:0]] <= NW'(in_weight[WEIGHT_BITS-1:0]);
    if (cmd.merge) begin
      weight_mem[slot_r[$clog2(SLOTS)-1:0]] <= min1_r + min2_r;
      parent_mem[lo_r[$clog2(SLOTS)-1:0]]   <= slot_r;
      parent_mem[hi_r[$clog2(SLOTS)-1:0]]   <= slot_r;
      is_left_mem[lo_r[$clog2(SLOTS)-1:0]]  <= 1'b1;
      is_left_mem[hi_r[$clog2(SLOTS)-1:0]]  <= 1'b0;
    end
  end

  // control registers: count, pointers, parent flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= '0;
      has_parent_r <= '0;
      slot_r       <= '0;
      ptr_r        <= '0;
      leaf_r       <= '0;
    end else begin
      if (cmd.load && leaf_count_r < CW'(MAX_LEAVES))
        leaf_count_r <= leaf_count_r + CW'(1);
      if (cmd.clear_count) begin
        leaf_count_r <= '0;
        has_parent_r <= '0;
        slot_r       <= '0;
        leaf_r       <= '0;
      end
      if (cmd.scan_start) begin
        ptr_r <= '0;
        if (slot_r == '0) slot_r <= leaf_count_x;
      end
      if (cmd.scan_step) ptr_r <= ptr_r + IW'(1);
      if (cmd.merge) begin
        has_parent_r[lo_r[$clog2(SLOTS)-1:0]] <= 1'b1;
        has_parent_r[hi_r[$clog2(SLOTS)-1:0]] <= 1'b1;
        slot_r <= slot_r + IW'(1);
      end
      if (cmd.next_leaf) leaf_r <= leaf_r + IW'(1);
    end
  end

  // track the two smallest free nodes, strict less-than
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      have1_r <= 1'b0;
      have2_r <= 1'b0;
    end else if (cmd.scan_step && !has_parent_r[ptr_r[$clog2(SLOTS)-1:0]]) begin
      if (!have1_r || scan_w < min1_r) begin
        min2_r  <= min1_r;
        hi_r    <= lo_r;
        have2_r <= have1_r;
        min1_r  <= scan_w;
        lo_r    <= ptr_r;
        have1_r <= 1'b1;
      end else if (!have2_r || scan_w < min2_r) begin
        min2_r  <= scan_w;
        hi_r    <= ptr_r;
        have2_r <= 1'b1;
      end
    end
  end

  // climb from leaf to root, one level per cycle
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      node_r  <= leaf_r;
      depth_r <= '0;
      code_r  <= '0;
    end else if (cmd.walk_step) begin
      if (!node_left && depth_r < 5'd15) code_r[depth_r[3:0]] <= 1'b1;
      depth_r <= depth_r + 5'd1;
      node_r  <= node_par;
    end
    if (cmd.emit) begin
      res_leaf_index  <= leaf_r[3:0];
      res_code_length <= depth_r[3:0];
      res_code_bits   <= code_r;
      res_last_code   <= sts.leaf_done;
    end
  end

endmodule

// ===== hw/rtl/hcb_ctrl.sv =====
// ---------------------------------------------------------------------------
// hcb_ctrl
// Sequencer for load, merge scans, code walks and result beats.
// ---------------------------------------------------------------------------
module hcb_ctrl import hcb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_last_leaf,
  output logic     out_valid,
  input  logic     out_stall,
  output hcb_cmd_t cmd,
  input  hcb_sts_t sts
);

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN_START, S_SCAN, S_MERGE, S_WALK_START, S_WALK, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign take      = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_LOAD: begin
        if (take) begin
          cmd.load = 1'b1;
          if (in_last_leaf) state_nxt = S_SCAN_START;
        end
      end
      S_SCAN_START: begin
        if (sts.single) state_nxt = S_WALK_START;
        else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_MERGE;
        else cmd.scan_step = 1'b1;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = sts.build_done ? S_WALK_START : S_SCAN_START;
      end
      S_WALK_START: begin
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) state_nxt = S_EMIT;
        else cmd.walk_step = 1'b1;
      end
      S_EMIT: begin
        // wait until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.leaf_done) begin
            cmd.clear_count = 1'b1;
            state_nxt       = S_LOAD;
          end else begin
            cmd.next_leaf = 1'b1;
            state_nxt     = S_WALK_START;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sim/huffman_code_builder_core_tb.sv =====
// ---------------------------------------------------------------------------
// huffman_code_builder_core_tb
// Streams groups of leaf weights into the code builder, predicts the code
// tree and each leaf's code in a local model, and checks every code beat.
// ---------------------------------------------------------------------------
module huffman_code_builder_core_tb;

  localparam int MAX_LEAVES = 16;
  localparam int NODES      = 2 * MAX_LEAVES - 1;

  typedef struct packed {
    logic [15:0] weight;
    logic        last_leaf;
  } leaf_beat_t;

  typedef struct packed {
    logic [3:0]  leaf_index;
    logic [3:0]  code_length;
    logic [14:0] code_bits;
    logic        last_code;
  } code_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_weight;
  logic        in_last_leaf;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_leaf_index;
  logic [3:0]  out_code_length;
  logic [14:0] out_code_bits;
  logic        out_last_code;

  huffman_code_builder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_weight(in_weight), .in_last_leaf(in_last_leaf),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_leaf_index(out_leaf_index), .out_code_length(out_code_length),
    .out_code_bits(out_code_bits), .out_last_code(out_last_code)
  );

  // Leaf store and tree, mirrored in the testbench
  logic [19:0] tree_weight [NODES];
  logic [4:0]  tree_parent [NODES];
  logic        tree_linked [NODES];
  logic        tree_left   [NODES];
  int          leaves_held;

  leaf_beat_t  pending_leaves[$];
  code_beat_t  expected_codes[$];
  int          errors;
  int          leaves_sent;
  int          codes_seen;
  int          trees_built;
  bit          hold_off_req;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  // Merge the two lightest parentless nodes until the root exists
  task automatic build_codes();
    int  n, j, k, lo, hi, c, depth;
    bit  have1, have2;
    logic [19:0] min1, min2;
    logic [14:0] code;
    code_beat_t  cb;
    n = leaves_held;
    for (k = 0; k < NODES; k++) tree_linked[k] = 0;
    for (j = n; j + 1 < 2 * n; j++) begin
      have1 = 0; have2 = 0; min1 = 0; min2 = 0; lo = 0; hi = 0;
      for (k = 0; k < j; k++) begin
        if (!tree_linked[k]) begin
          if (!have1 || tree_weight[k] < min1) begin
            min2 = min1; hi = lo; have2 = have1;
            min1 = tree_weight[k]; lo = k; have1 = 1;
          end else if (!have2 || tree_weight[k] < min2) begin
            min2 = tree_weight[k]; hi = k; have2 = 1;
          end
        end
      end
      tree_weight[j] = min1 + min2;
      tree_parent[lo] = 5'(j); tree_linked[lo] = 1; tree_left[lo] = 1;
      tree_parent[hi] = 5'(j); tree_linked[hi] = 1; tree_left[hi] = 0;
    end
    // Climb from each leaf; the first bit found lands least significant
    for (k = 0; k < n; k++) begin
      c = k; depth = 0; code = '0;
      while (tree_linked[c] && depth < NODES) begin
        if (!tree_left[c] && depth < 15) code[depth] = 1'b1;
        depth++;
        c = tree_parent[c];
      end
      cb.leaf_index  = k[3:0];
      cb.code_length = depth[3:0];
      cb.code_bits   = code;
      cb.last_code   = (k + 1 == n);
      expected_codes.push_back(cb);
    end
    leaves_held = 0;
    trees_built++;
  endtask

  task automatic accept_leaf(leaf_beat_t b);
    if (leaves_held < MAX_LEAVES) begin
      tree_weight[leaves_held] = {4'b0, b.weight};
      leaves_held++;
    end
    if (b.last_leaf) build_codes();
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'hffff;
      1: return 16'h0000;
      2: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_group(int n, int style);
    leaf_beat_t b;
    for (int i = 0; i < n; i++) begin
      case (style)
        0: b.weight = pick_weight();
        1: b.weight = 16'd5;
        2: b.weight = 16'hffff;
        default: b.weight = 16'd1 << (i % 16);
      endcase
      b.last_leaf = (i == n - 1);
      pending_leaves.push_back(b);
    end
  endtask

  // Driver: offer queued leaves with random gaps
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_weight <= '0;
      in_last_leaf <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        accept_leaf({in_weight, in_last_leaf});
        leaves_sent++;
      end
      if (in_valid && in_stall) begin
        // hold the beat
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_leaves.size() > 0) begin
        {in_weight, in_last_leaf} <= pending_leaves.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random stall, one long hold-off on request, check code beats
  int hold_cycles;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          $error("unexpected code beat for leaf %0d", out_leaf_index);
          errors++;
        end else begin
          code_beat_t e;
          e = expected_codes.pop_front();
          if (out_leaf_index !== e.leaf_index) begin
            $error("leaf_index: expected %0d, got %0d", e.leaf_index, out_leaf_index);
            errors++;
          end
          if (out_code_length !== e.code_length) begin
            $error("code_length: expected %0d, got %0d", e.code_length, out_code_length);
            errors++;
          end
          if (out_code_bits !== e.code_bits) begin
            $error("code_bits: expected %h, got %h", e.code_bits, out_code_bits);
            errors++;
          end
          if (out_last_code !== e.last_code) begin
            $error("last_code: expected %0d, got %0d", e.last_code, out_last_code);
            errors++;
          end
        end
      end
      if (hold_off_req && hold_cycles == 0) begin
        hold_off_req <= 1'b0;
        hold_cycles <= 3000;
        out_stall <= 1'b1;
      end else if (hold_cycles > 1) begin
        hold_cycles <= hold_cycles - 1;
      end else if (hold_cycles == 1) begin
        hold_cycles <= 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= (pick_gap() > 0);
      end
    end
  end

  initial begin
    int n;
    errors = 0; leaves_sent = 0; codes_seen = 0; trees_built = 0;
    leaves_held = 0; hold_off_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_weight = '0; in_last_leaf = 1'b0; out_stall = 1'b0;

    // Directed: single leaf, pair, ties, max weights, powers, full and overflow
    push_group(1, 0);
    push_group(2, 2);
    push_group(4, 1);
    push_group(16, 3);
    push_group(16, 2);
    push_group(3, 0);
    for (int i = 0; i < 3; i++)
      pending_leaves.push_back('{weight: 16'($urandom), last_leaf: 1'b0});
    push_group(18, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_leaves.size() == 0);

    // Long receiver hold-off while two full trees are offered
    hold_off_req = 1;
    push_group(16, 0);
    push_group(16, 0);

    // Random groups, mostly small and few at full size
    while (pending_leaves.size() + leaves_sent < 450) begin
      n = ($urandom_range(0, 9) < 2) ? $urandom_range(12, 20) : $urandom_range(1, 8);
      push_group(n, ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 3));
    end
    wait (pending_leaves.size() == 0 && !in_valid);
    wait (expected_codes.size() == 0);
    repeat (500) @(posedge clk);

    $display("Loaded %0d leaf beats into %0d trees; checked %0d code beats.",
             leaves_sent, trees_built, codes_seen);
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
